// ----- rtl/core/swmm_pkg.sv -----
// shared types for the sliding window min/max block
`timescale 1ns / 1ps
package swmm_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan_rd;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic produce;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/core/sliding_window_min_max.sv -----
// top level of the sliding window minimum/maximum block
//
//  channel   direction  payload
//  req_      in         tdata: sample; tuser: start_req
//  rsp_      out        tdata: window_min, window_max
//  csr_      in         data: window_len
//
// an item that completes a window starts a scan: the history
// memory is read one sample a cycle over the window, then after a drain state
// the result loads once the output register is free; an item that completes no window needs no scan
// reset clears the span, the write pointer and the result valid flag; the history needs no clear
// a stalled result holds, and the next item is taken while it waits
`timescale 1ns / 1ps
module sliding_window_min_max
   import swmm_pkg::*;
#(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,  // sample
   input  logic                                    req_tuser,  // start_req
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // window_min, window_max
   output logic [((2 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [6:0]                              csr_data   // window_len
);

   localparam int RW = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;

   cmd_type                        cmd;
   status_type                     status;
   logic [6:0]                     window_len_ff;
   logic signed [SAMPLE_WIDTH-1:0] window_min;
   logic signed [SAMPLE_WIDTH-1:0] window_max;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= 7'd1;
      end else if (csr_valid) begin
         window_len_ff <= csr_data;
      end
   end

   swmm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   swmm_dp #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .window_len (window_len_ff),
      .sample     (req_tdata[SAMPLE_WIDTH-1:0]),
      .start_req  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .window_min (window_min),
      .window_max (window_max)
   );

   assign rsp_tdata = RW'({window_max, window_min});

endmodule

// ----- rtl/core/swmm_ctrl.sv -----
// controller state machine sequencing accept, window scan and result load
`timescale 1ns / 1ps
module swmm_ctrl
   import swmm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (status.produce) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/swmm_dp.sv -----
// datapath: sample history memory, window span, min/max scan and result register
`timescale 1ns / 1ps
module swmm_dp
   import swmm_pkg::*;
#(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [6:0]                     window_len,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic                           start_req,
   input  cmd_type                        cmd,
   output status_type                     status,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] window_min,
   output logic signed [SAMPLE_WIDTH-1:0] window_max
);

   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int WW = $clog2(WINDOW_MAX + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_MAX - 1);

   logic signed [SAMPLE_WIDTH-1:0] mem [WINDOW_MAX];

   logic [AW-1:0]                  wptr_ff;
   logic [AW-1:0]                  rptr_ff;
   logic [WW-1:0]                  span_ff;
   logic [WW-1:0]                  span_in;
   logic [WW-1:0]                  cnt_ff;
   logic [WW-1:0]                  win;
   logic                           rv_ff;
   logic                           first_ff;
   logic signed [SAMPLE_WIDTH-1:0] rdata_ff;
   logic signed [SAMPLE_WIDTH-1:0] acc_min_ff;
   logic signed [SAMPLE_WIDTH-1:0] acc_max_ff;
   logic                           out_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_min_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_max_ff;

   always_comb begin
      if (window_len == 7'd0) begin
         win = WW'(1);
      end else if (32'(window_len) > 32'(WINDOW_MAX)) begin
         win = WW'(WINDOW_MAX);
      end else begin
         win = WW'(window_len);
      end
      if (start_req) begin
         span_in = WW'(1);
      end else if (span_ff >= win) begin
         span_in = win;
      end else begin
         span_in = span_ff + WW'(1);
      end
   end

   assign status.produce   = (span_in == win);
   assign status.scan_last = (cnt_ff == span_ff - WW'(1));
   assign status.out_free  = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mem[wptr_ff] <= sample;
      end
      rdata_ff <= mem[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff      <= '0;
         span_ff      <= '0;
         rv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rv_ff <= cmd.scan_rd;
         if (cmd.accept) begin
            span_ff <= span_in;
            wptr_ff <= (wptr_ff == LAST_ADDR) ? '0 : wptr_ff + AW'(1);
         end
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rptr_ff  <= wptr_ff;
         cnt_ff   <= '0;
         first_ff <= 1'b1;
      end else if (cmd.scan_rd) begin
         rptr_ff <= (rptr_ff == '0) ? LAST_ADDR : rptr_ff - AW'(1);
         cnt_ff  <= cnt_ff + WW'(1);
      end
      if (rv_ff) begin
         first_ff <= 1'b0;
         if (first_ff || rdata_ff < acc_min_ff) begin
            acc_min_ff <= rdata_ff;
         end
         if (first_ff || rdata_ff > acc_max_ff) begin
            acc_max_ff <= rdata_ff;
         end
      end
      if (cmd.load_out) begin
         out_min_ff <= acc_min_ff;
         out_max_ff <= acc_max_ff;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign window_min = out_min_ff;
   assign window_max = out_max_ff;

endmodule
